### hdl/optimal_bst_cost_table_assert.svh
// Assertion macros used by the port checker.
`ifndef OPTIMAL_BST_COST_TABLE_ASSERT_SVH
`define OPTIMAL_BST_COST_TABLE_ASSERT_SVH

// Same-cycle implication.
`define OBCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obct assertion failed");

// Next-cycle implication.
`define OBCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obct assertion failed");

`endif

### hdl/obct_pkg.sv
// Types, codes and constants of the optimal BST cost table.
`default_nettype none
package obct_pkg;

   localparam int MAX_KEYS_DEF = 16;
   localparam int PROB_W       = 16;
   localparam int COST_W       = 24;
   localparam int ROOT_W       = 5;
   localparam int NKEY_W       = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam logic [NKEY_W-1:0] NKEY_RESET = 5'd8;
   localparam logic [CSR_ADDR_W-3:0] CSR_N_KEYS = 1'b0;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] ST_ANSWER = 2'd0;
   localparam logic [1:0] ST_DONE   = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [3:0]        key_index;
      logic [PROB_W-1:0] prob;
      logic [4:0]        span_start;
      logic [4:0]        span_end;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [COST_W-1:0] best_cost;
      logic [ROOT_W-1:0] best_root;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_CLEAR    = 3'd1,
      OP_ACCEPT   = 3'd2,
      OP_DIAG     = 3'd3,
      OP_IVL_INIT = 3'd4,
      OP_ISSUE    = 3'd5,
      OP_WRITE    = 3'd6,
      OP_EMIT     = 3'd7
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic diag_last;
      logic r_last;
      logic hi_last;
      logic d_last;
      logic n_zero;
      logic q_bad;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

### hdl/obct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module obct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hdl/obct_ctrl.sv
// Sequencer for clearing, loads, the table run and queries.
`default_nettype none
module obct_ctrl import obct_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_cmd,
   input  wire dp_stat_type  stat,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_DIAG     = 9'b000000100,
      S_IVL_INIT = 9'b000001000,
      S_ISSUE    = 9'b000010000,
      S_DRAIN    = 9'b000100000,
      S_WRITE    = 9'b001000000,
      S_READ     = 9'b010000000,
      S_EMIT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               case (req_cmd)
                  CMD_RUN:   state_in = S_DIAG;
                  CMD_QUERY: state_in = stat.q_bad ? S_EMIT : S_READ;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_DIAG: begin
            cmd.op = OP_DIAG;
            if (stat.diag_last) state_in = stat.n_zero ? S_READ : S_IVL_INIT;
         end
         S_IVL_INIT: begin
            cmd.op   = OP_IVL_INIT;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.op = OP_ISSUE;
            if (stat.r_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = (stat.hi_last && stat.d_last) ? S_READ : S_IVL_INIT;
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/obct_dpath.sv
// Datapath: probability and table memories, interval counters, min search.
`default_nettype none
module obct_dpath import obct_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF,
   parameter int IW = $clog2(MAX_KEYS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_stat_type        stat,
   input  wire req_type       req_data,
   input  wire logic [IW-1:0] n_eff,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data
);

   localparam int SIDE  = MAX_KEYS + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int PAW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int WW    = PROB_W + IW;
   localparam int SW    = COST_W + 1;

   logic [AW-1:0]     clr_addr_ff;
   logic [IW-1:0]     d_ff, lo_ff, r_ff, iss_r_ff, best_r_ff;
   logic [AW-1:0]     lo_base_ff, a_addr_ff, b_addr_ff, rd_addr_ff;
   logic [1:0]        out_st_ff;
   logic [WW-1:0]     weight_ff;
   logic [SW-1:0]     best_ff;
   logic              have_ff, iss_v_ff, rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [IW-1:0]     hi;
   logic [AW-1:0]     q_addr, wr_addr, rd_a;
   logic              wr_en, prob_we, q_bad;
   logic [COST_W-1:0] wr_cost, qa, qb;
   logic [ROOT_W-1:0] wr_root, qr;
   logic [PROB_W-1:0] qp;
   logic [SW-1:0]     sum;

   assign hi     = lo_ff + d_ff;
   assign q_bad  = (req_data.span_start > req_data.span_end) ||
                   (32'(req_data.span_end) > 32'(n_eff));
   assign q_addr = AW'(32'(req_data.span_start) * SIDE + 32'(req_data.span_end));
   assign prob_we = (cmd.op == OP_ACCEPT) && (req_data.cmd == CMD_LOAD) &&
                    (32'(req_data.key_index) < MAX_KEYS);
   assign rd_a   = (cmd.op == OP_ISSUE) ? a_addr_ff : rd_addr_ff;
   assign sum    = SW'(qa) + SW'(qb);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_cost = '0;
      wr_root = '0;
      case (cmd.op)
         OP_CLEAR: wr_en = 1'b1;
         OP_DIAG: begin
            wr_en   = 1'b1;
            wr_addr = lo_base_ff + AW'(lo_ff);
            wr_root = ROOT_W'(lo_ff);
         end
         OP_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = lo_base_ff + AW'(hi);
            wr_cost = best_ff[COST_W-1:0] + COST_W'(weight_ff);
            wr_root = ROOT_W'(best_r_ff);
         end
         default: ;
      endcase
   end

   obct_ram #(.WIDTH(PROB_W), .DEPTH(MAX_KEYS)) u_prob (
      .clock(clock), .wr_en(prob_we), .wr_addr(PAW'(req_data.key_index)),
      .wr_data(req_data.prob), .rd_addr(PAW'(r_ff)), .rd_data(qp));

   obct_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_cost),
      .rd_addr(rd_a), .rd_data(qa));

   obct_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_cost),
      .rd_addr(b_addr_ff), .rd_data(qb));

   obct_ram #(.WIDTH(ROOT_W), .DEPTH(DEPTH)) u_root (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_root),
      .rd_addr(rd_addr_ff), .rd_data(qr));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         iss_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_addr_ff <= clr_addr_ff + AW'(1);
         iss_v_ff <= (cmd.op == OP_ISSUE);
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            lo_ff      <= '0;
            d_ff       <= '0;
            lo_base_ff <= '0;
            if (req_data.cmd == CMD_RUN) begin
               out_st_ff  <= ST_DONE;
               rd_addr_ff <= AW'(n_eff);
            end else begin
               out_st_ff  <= q_bad ? ST_RANGE : ST_ANSWER;
               rd_addr_ff <= q_addr;
            end
         end
         OP_DIAG, OP_WRITE: begin
            if ((cmd.op == OP_DIAG) ? (lo_ff == n_eff) : (hi == n_eff)) begin
               d_ff       <= d_ff + IW'(1);
               lo_ff      <= '0;
               lo_base_ff <= '0;
            end else begin
               lo_ff      <= lo_ff + IW'(1);
               lo_base_ff <= lo_base_ff + AW'(SIDE);
            end
         end
         OP_IVL_INIT: begin
            r_ff      <= lo_ff;
            a_addr_ff <= lo_base_ff + AW'(lo_ff);
            b_addr_ff <= lo_base_ff + AW'(SIDE) + AW'(hi);
            weight_ff <= '0;
            have_ff   <= 1'b0;
         end
         OP_ISSUE: begin
            r_ff      <= r_ff + IW'(1);
            a_addr_ff <= a_addr_ff + AW'(1);
            b_addr_ff <= b_addr_ff + AW'(SIDE);
            iss_r_ff  <= r_ff;
         end
         OP_EMIT: begin
            rsp_data_ff.status    <= out_st_ff;
            rsp_data_ff.best_cost <= (out_st_ff == ST_RANGE) ? '0 : qa;
            rsp_data_ff.best_root <= (out_st_ff == ST_RANGE) ? '0 : qr;
         end
         default: ;
      endcase
      if (iss_v_ff) begin
         weight_ff <= weight_ff + WW'(qp);
         if (!have_ff || (sum < best_ff)) begin
            best_ff   <= sum;
            best_r_ff <= iss_r_ff;
            have_ff   <= 1'b1;
         end
      end
   end

   assign stat.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   assign stat.diag_last = (lo_ff == n_eff);
   assign stat.r_last    = ((r_ff + IW'(1)) == hi);
   assign stat.hi_last   = (hi == n_eff);
   assign stat.d_last    = (d_ff == n_eff);
   assign stat.n_zero    = (n_eff == '0);
   assign stat.q_bad     = q_bad;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### hdl/optimal_bst_cost_table.sv
// Optimal BST cost table: after reset a clearing pass over all (MAX_KEYS+1)^2
// table entries (289 at the default) zeroes the tables while req_stall is high.
// A load is taken in the idle state; a query is accepted, read and emitted, with
// the read skipped when out of range. A run is accepted, fills the diagonal, then
// for each nonempty interval (n(n+1)/2 of them) initialises, issues each root
// candidate (n(n+1)(n+2)/6 candidates in all), drains and writes, then reads and
// emits. The candidate loop reads two cost entries per cycle from duplicated cost
// memories. Items are handled one at a time; a finished transfer may wait in the
// output register while the next item is taken.
`default_nettype none
module optimal_bst_cost_table import obct_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IW = $clog2(MAX_KEYS + 1);

   logic [NKEY_W-1:0] n_keys_ff;
   logic [IW-1:0]     n_eff;
   logic              csr_hit;
   ctrl_cmd_type      cmd;
   dp_stat_type       stat;

   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_N_KEYS);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(n_keys_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_keys_ff <= NKEY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         n_keys_ff <= csr_pwdata[NKEY_W-1:0];
      end
   end

   assign n_eff = (32'(n_keys_ff) > MAX_KEYS) ? IW'(MAX_KEYS) : IW'(n_keys_ff);

   obct_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_data.cmd), .stat(stat), .cmd(cmd));

   obct_dpath #(.MAX_KEYS(MAX_KEYS), .IW(IW)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_data(req_data),
      .n_eff(n_eff), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data));

endmodule
`default_nettype wire

### hdl/obct_port_checker.sv
// Port-level checker for the optimal BST cost table, bound to the top level.
`default_nettype none
`include "optimal_bst_cost_table_assert.svh"
module obct_port_checker import obct_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data,
   input wire logic    csr_pready
);

   `OBCT_ASSERT_NOW(a_clear_stalls, clock, reset, $fell(reset), req_stall)
   `OBCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `OBCT_ASSERT_NOW(a_range_zero, clock, reset,
      rsp_valid && (rsp_data.status == ST_RANGE),
      (rsp_data.best_cost == '0) && (rsp_data.best_root == '0))
   `OBCT_ASSERT_NOW(a_status_code, clock, reset, rsp_valid,
      (rsp_data.status == ST_ANSWER) || (rsp_data.status == ST_DONE) ||
      (rsp_data.status == ST_RANGE))
   `OBCT_ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind optimal_bst_cost_table obct_port_checker u_port_checker (.*);
`default_nettype wire
